// File: src/winged_edge_ring_walker_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the winged-edge ring walker.
// Every assertion of the project is written through one of these macros.
// ----------------------------------------------------------------------------
`ifndef WINGED_EDGE_RING_WALKER_CORE_ASSERT_SVH
`define WINGED_EDGE_RING_WALKER_CORE_ASSERT_SVH

// Property checked on every rising edge, suspended while reset is high.
`define WERW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("winged edge ring walker: assertion failed");

// Property checked on every rising edge, reset included.
`define WERW_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("winged edge ring walker: assertion failed");

`endif

// File: src/werw_pkg.sv
// ----------------------------------------------------------------------------
// werw_pkg
// Types and constants shared by the winged-edge ring walker modules.
// ----------------------------------------------------------------------------
package werw_pkg;

   localparam int EdgeIdWidth = 11;
   localparam int FaceWidth   = 10;
   localparam int StatusWidth = 3;

   // Request kinds.
   localparam logic ReqWrite = 1'b0;
   localparam logic ReqWalk  = 1'b1;

   // Result status codes.
   localparam logic [StatusWidth-1:0] StatusOk       = 3'd0;
   localparam logic [StatusWidth-1:0] StatusSameFace = 3'd1;
   localparam logic [StatusWidth-1:0] StatusNoFace   = 3'd2;
   localparam logic [StatusWidth-1:0] StatusBadId    = 3'd3;
   localparam logic [StatusWidth-1:0] StatusTooLong  = 3'd4;

   // One winged-edge record as kept in the table.
   typedef struct packed {
      logic [FaceWidth-1:0]   left_face;
      logic [FaceWidth-1:0]   right_face;
      logic [EdgeIdWidth-1:0] left_next;
      logic [EdgeIdWidth-1:0] right_next;
   } edge_rec_type;

   localparam int RecWidth = $bits(edge_rec_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr_rec;     // store the record of the request being accepted
      logic load_walk;  // latch start edge and face of an accepted walk
      logic rd_rec;     // read the record of the current edge
      logic load_bad;   // build a bad-id result for the current edge
      logic eval;       // judge the record just read and build a result
      logic load_long;  // build the ring-too-long result
      logic advance;    // move on to the next edge of the ring
   } werw_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cur_ok;     // current edge id lies inside the table
      logic rsp_last;   // the held result ends the walk
      logic pend_long;  // a ring-too-long result follows the held one
   } werw_stat_type;

endpackage

// File: src/werw_ram.sv
// ----------------------------------------------------------------------------
// werw_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module werw_ram #(
   parameter int Width = 42,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/werw_ctrl.sv
// ----------------------------------------------------------------------------
// werw_ctrl
// Controller of the ring walker: takes requests, sequences the record
// reads of a walk and hands each result beat to the output channel.
// ----------------------------------------------------------------------------
module werw_ctrl
   import werw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_type,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  werw_stat_type stat,
   output werw_cmd_type  cmd
);

   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StCheck = 2'd1;
   localparam logic [1:0] StEval  = 2'd2;
   localparam logic [1:0] StOut   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = (state_ff == StOut);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         StIdle: begin
            if (req_fire) begin
               if (req_type == ReqWalk) begin
                  cmd.load_walk = 1'b1;
                  state_in      = StCheck;
               end else begin
                  cmd.wr_rec = 1'b1;
               end
            end
         end
         StCheck: begin
            if (stat.cur_ok) begin
               cmd.rd_rec = 1'b1;
               state_in   = StEval;
            end else begin
               cmd.load_bad = 1'b1;
               state_in     = StOut;
            end
         end
         StEval: begin
            cmd.eval = 1'b1;
            state_in = StOut;
         end
         StOut: begin
            if (rsp_fire) begin
               if (stat.rsp_last) begin
                  state_in = StIdle;
               end else if (stat.pend_long) begin
                  cmd.load_long = 1'b1;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = StCheck;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/werw_dp.sv
// ----------------------------------------------------------------------------
// werw_dp
// Datapath of the ring walker: the edge table, the walk registers and the
// result register.
// ----------------------------------------------------------------------------
module werw_dp
   import werw_pkg::*;
#(
   parameter int NUM_EDGES      = 1024,
   parameter int MAX_RING_EDGES = 63
) (
   input  logic                   clock,
   input  logic                   reset,
   input  werw_cmd_type           cmd,
   output werw_stat_type          stat,
   input  logic [EdgeIdWidth-1:0] req_edge_addr,
   input  logic [FaceWidth-1:0]   req_left_face,
   input  logic [FaceWidth-1:0]   req_right_face,
   input  logic [EdgeIdWidth-1:0] req_left_next,
   input  logic [EdgeIdWidth-1:0] req_right_next,
   input  logic [EdgeIdWidth-1:0] req_start_edge,
   input  logic [FaceWidth-1:0]   req_walk_face,
   output logic [EdgeIdWidth-1:0] rsp_edge_id,
   output logic                   rsp_last,
   output logic [StatusWidth-1:0] rsp_status
);

   localparam int AddrWidth  = $clog2(NUM_EDGES);
   localparam int CntBits    = $clog2(NUM_EDGES + 1);
   localparam int CmpWidth   = (CntBits > EdgeIdWidth) ? CntBits : EdgeIdWidth;
   localparam int CountWidth = $clog2(MAX_RING_EDGES + 1);
   localparam logic [CmpWidth-1:0]   NumEdgesVal = CmpWidth'(NUM_EDGES);
   localparam logic [CmpWidth-1:0]   OneVal      = CmpWidth'(1);
   localparam logic [CountWidth-1:0] MaxCount    = CountWidth'(MAX_RING_EDGES);
   localparam logic [CountWidth-1:0] CountOne    = CountWidth'(1);

   logic [EdgeIdWidth-1:0] cur_ff, cur_in;
   logic [EdgeIdWidth-1:0] start_ff, start_in;
   logic [FaceWidth-1:0]   face_ff, face_in;
   logic [EdgeIdWidth-1:0] next_ff, next_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   pend_long_ff, pend_long_in;
   logic [EdgeIdWidth-1:0] rsp_edge_id_ff, rsp_edge_id_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [StatusWidth-1:0] rsp_status_ff, rsp_status_in;

   logic [CmpWidth-1:0]    wr_id_ext, wr_idx;
   logic [CmpWidth-1:0]    cur_id_ext, cur_idx;
   logic                   wr_ok;
   logic                   cur_ok;
   edge_rec_type           wr_rec;
   logic [RecWidth-1:0]    rd_data;
   edge_rec_type           rec;
   logic                   match_right;
   logic                   match_left;
   logic [EdgeIdWidth-1:0] follow;
   logic [CountWidth-1:0]  count_plus;

   // One-based ids map to zero-based table rows.
   assign wr_id_ext  = CmpWidth'(req_edge_addr);
   assign wr_ok      = (req_edge_addr != '0) && (wr_id_ext <= NumEdgesVal);
   assign wr_idx     = wr_id_ext - OneVal;
   assign cur_id_ext = CmpWidth'(cur_ff);
   assign cur_ok     = (cur_ff != '0) && (cur_id_ext <= NumEdgesVal);
   assign cur_idx    = cur_id_ext - OneVal;

   assign wr_rec.left_face  = req_left_face;
   assign wr_rec.right_face = req_right_face;
   assign wr_rec.left_next  = req_left_next;
   assign wr_rec.right_next = req_right_next;

   werw_ram #(
      .Width (RecWidth),
      .Depth (NUM_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_rec && wr_ok),
      .wr_addr (wr_idx[AddrWidth-1:0]),
      .wr_data (wr_rec),
      .rd_en   (cmd.rd_rec),
      .rd_addr (cur_idx[AddrWidth-1:0]),
      .rd_data (rd_data)
   );

   assign rec         = edge_rec_type'(rd_data);
   assign match_right = (rec.right_face == face_ff);
   assign match_left  = (rec.left_face == face_ff);
   // The right side wins when the face lies on both sides.
   assign follow      = match_right ? rec.right_next : rec.left_next;
   assign count_plus  = count_ff + CountOne;

   always_comb begin
      cur_in         = cur_ff;
      start_in       = start_ff;
      face_in        = face_ff;
      next_in        = next_ff;
      count_in       = count_ff;
      pend_long_in   = pend_long_ff;
      rsp_edge_id_in = rsp_edge_id_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_status_in  = rsp_status_ff;

      if (cmd.load_walk) begin
         cur_in       = req_start_edge;
         start_in     = req_start_edge;
         face_in      = req_walk_face;
         count_in     = '0;
         pend_long_in = 1'b0;
      end

      if (cmd.load_bad) begin
         rsp_edge_id_in = cur_ff;
         rsp_last_in    = 1'b1;
         rsp_status_in  = StatusBadId;
      end

      if (cmd.eval) begin
         rsp_edge_id_in = cur_ff;
         if (rec.left_face == rec.right_face) begin
            rsp_last_in   = 1'b1;
            rsp_status_in = StatusSameFace;
         end else if (!match_right && !match_left) begin
            rsp_last_in   = 1'b1;
            rsp_status_in = StatusNoFace;
         end else if (follow == start_ff) begin
            rsp_last_in   = 1'b1;
            rsp_status_in = StatusOk;
         end else begin
            rsp_last_in   = 1'b0;
            rsp_status_in = StatusOk;
            next_in       = follow;
            count_in      = count_plus;
            pend_long_in  = (count_plus == MaxCount);
         end
      end

      if (cmd.load_long) begin
         rsp_edge_id_in = next_ff;
         rsp_last_in    = 1'b1;
         rsp_status_in  = StatusTooLong;
         pend_long_in   = 1'b0;
      end

      if (cmd.advance) begin
         cur_in = next_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         count_ff     <= '0;
         pend_long_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         count_ff     <= count_in;
         pend_long_ff <= pend_long_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff       <= start_in;
      face_ff        <= face_in;
      next_ff        <= next_in;
      rsp_edge_id_ff <= rsp_edge_id_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign stat.cur_ok    = cur_ok;
   assign stat.rsp_last  = rsp_last_ff;
   assign stat.pend_long = pend_long_ff;

   assign rsp_edge_id = rsp_edge_id_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

// File: src/winged_edge_ring_walker_core.sv
// ----------------------------------------------------------------------------
// winged_edge_ring_walker_core - winged-edge table with face ring traversal.
// Write: stored when accepted; the next request can be taken in the next cycle.
// Walk: per edge, an id check with one record read, an evaluation and an output beat;
// an id outside the table skips the evaluation, and a too-long beat follows from the output state.
// Sync reset clears control; the edge table itself is not cleared.
// ----------------------------------------------------------------------------
//
// The block keeps a table of winged-edge records, addressed by one-based
// edge ids. A write request stores one record in the cycle it is accepted;
// a write to id zero or to an id beyond the table is dropped silently and
// produces no beat.
//
// A walk request names a start edge and a face. The controller reads the
// record of the current edge, the datapath judges it and loads one result
// beat into the output register, and the walk moves on along the next-edge
// of the side on which the face lies (the right side is checked first).
// The walk stops when the next edge equals the start edge, and that beat
// carries last. An id outside the table, a record with the same face on
// both sides, or a record that does not border the face ends the walk with
// one error beat. After MAX_RING_EDGES good beats without closing the ring,
// one more beat names the edge that would come next, with a too-long status.
//
// Each edge goes through the id check and RAM read, the evaluation of the
// registered read data, and the beat on the output channel. One request is
// worked on at a time; req_ready is high only while no walk is in progress,
// so a walk holds off further requests until its last beat is taken.
//
// Reading a record that was never written gives undefined fields.
// ----------------------------------------------------------------------------
module winged_edge_ring_walker_core
   import werw_pkg::*;
#(
   parameter int NUM_EDGES      = 1024,
   parameter int MAX_RING_EDGES = 63
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_type,
   input  logic [EdgeIdWidth-1:0] req_edge_addr,
   input  logic [FaceWidth-1:0]   req_left_face,
   input  logic [FaceWidth-1:0]   req_right_face,
   input  logic [EdgeIdWidth-1:0] req_left_next,
   input  logic [EdgeIdWidth-1:0] req_right_next,
   input  logic [EdgeIdWidth-1:0] req_start_edge,
   input  logic [FaceWidth-1:0]   req_walk_face,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [EdgeIdWidth-1:0] rsp_edge_id,
   output logic                   rsp_last,
   output logic [StatusWidth-1:0] rsp_status
);

   werw_cmd_type  cmd;
   werw_stat_type stat;

   // The controller decides what happens in each cycle; it sees only the
   // handshakes, the request kind and a few status flags from the datapath.
   werw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the edge table, the walk registers and the output
   // register, which keeps the beat stable while the consumer stalls.
   werw_dp #(
      .NUM_EDGES      (NUM_EDGES),
      .MAX_RING_EDGES (MAX_RING_EDGES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_edge_addr  (req_edge_addr),
      .req_left_face  (req_left_face),
      .req_right_face (req_right_face),
      .req_left_next  (req_left_next),
      .req_right_next (req_right_next),
      .req_start_edge (req_start_edge),
      .req_walk_face  (req_walk_face),
      .rsp_edge_id    (rsp_edge_id),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

endmodule

// File: src/werw_checker.sv
// ----------------------------------------------------------------------------
// werw_checker
// Port-level checks of the ring walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "winged_edge_ring_walker_core_assert.svh"

module werw_checker
   import werw_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [EdgeIdWidth-1:0] rsp_edge_id,
   input logic                   rsp_last,
   input logic [StatusWidth-1:0] rsp_status
);

   // A stalled beat holds its payload.
   `WERW_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_edge_id) && $stable(rsp_last) && $stable(rsp_status))

   // No request is taken while a beat of a walk is pending.
   `WERW_ASSERT(a_one_at_a_time, clock, reset, !(req_ready && rsp_valid))

   // An error beat always ends the walk.
   `WERW_ASSERT(a_error_is_last, clock, reset, rsp_valid && (rsp_status != StatusOk) |-> rsp_last)

   // Only defined status codes appear.
   `WERW_ASSERT(a_status_code, clock, reset, rsp_valid |-> (rsp_status <= StatusTooLong))

   // After the last beat is taken the block is ready for the next request.
   `WERW_ASSERT(a_ready_after_last, clock, reset, rsp_valid && rsp_ready && rsp_last |=> req_ready)

endmodule

bind winged_edge_ring_walker_core werw_checker u_werw_checker (.*);

// File: test/ring_walk_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_walk_scoreboard_pkg
// Shadow edge table, face ring predictor and beat checker for the walker test.
// ----------------------------------------------------------------------------
package ring_walk_scoreboard_pkg;
   import werw_pkg::*;

   localparam int TableDepth = 1024;
   localparam int RingLimit  = 63;

   // One request beat as seen on the input channel.
   typedef struct packed {
      logic                   kind;
      logic [EdgeIdWidth-1:0] edge_addr;
      logic [FaceWidth-1:0]   left_face;
      logic [FaceWidth-1:0]   right_face;
      logic [EdgeIdWidth-1:0] left_next;
      logic [EdgeIdWidth-1:0] right_next;
      logic [EdgeIdWidth-1:0] start_edge;
      logic [FaceWidth-1:0]   walk_face;
   } ring_request_type;

   // One result beat of a walk.
   typedef struct packed {
      logic [EdgeIdWidth-1:0] edge_id;
      logic                   last;
      logic [StatusWidth-1:0] status;
   } walk_beat_type;

   class ring_walk_scoreboard;
      edge_rec_type           edge_recs [0:TableDepth];
      bit                     written [0:TableDepth];
      logic [EdgeIdWidth-1:0] written_ids [$];
      walk_beat_type          traced [$];
      walk_beat_type          awaited_beats [$];
      int                     beat_count;
      int                     errors;

      // Writes outside the table are dropped, just as the block drops them.
      function void store_record(logic [EdgeIdWidth-1:0] addr, edge_rec_type rec);
         if (addr == 0 || addr > TableDepth) return;
         edge_recs[addr] = rec;
         if (!written[addr]) written_ids.push_back(addr);
         written[addr] = 1'b1;
      endfunction

      // Fills traced with the beats of one walk. Returns 1 when the walk would
      // read a record that was never written; traced is then incomplete.
      function bit trace_walk(logic [EdgeIdWidth-1:0] start, logic [FaceWidth-1:0] face);
         logic [EdgeIdWidth-1:0] cur;
         logic [EdgeIdWidth-1:0] onward;
         edge_rec_type           rec;
         int                     ok_beats;
         traced.delete();
         cur = start;
         ok_beats = 0;
         while (1) begin
            if (cur == 0 || cur > TableDepth) begin
               traced.push_back('{edge_id: cur, last: 1'b1, status: StatusBadId});
               return 1'b0;
            end
            if (!written[cur]) return 1'b1;
            rec = edge_recs[cur];
            if (rec.left_face == rec.right_face) begin
               traced.push_back('{edge_id: cur, last: 1'b1, status: StatusSameFace});
               return 1'b0;
            end
            if (rec.right_face == face) begin
               onward = rec.right_next;
            end else if (rec.left_face == face) begin
               onward = rec.left_next;
            end else begin
               traced.push_back('{edge_id: cur, last: 1'b1, status: StatusNoFace});
               return 1'b0;
            end
            if (onward == start) begin
               traced.push_back('{edge_id: cur, last: 1'b1, status: StatusOk});
               return 1'b0;
            end
            traced.push_back('{edge_id: cur, last: 1'b0, status: StatusOk});
            ok_beats++;
            if (ok_beats >= RingLimit) begin
               traced.push_back('{edge_id: onward, last: 1'b1, status: StatusTooLong});
               return 1'b0;
            end
            cur = onward;
         end
      endfunction

      function void note_request(ring_request_type rq);
         edge_rec_type rec;
         if (rq.kind == ReqWrite) begin
            rec.left_face  = rq.left_face;
            rec.right_face = rq.right_face;
            rec.left_next  = rq.left_next;
            rec.right_next = rq.right_next;
            store_record(rq.edge_addr, rec);
         end else begin
            void'(trace_walk(rq.start_edge, rq.walk_face));
            foreach (traced[i]) awaited_beats.push_back(traced[i]);
         end
      endfunction

      function int beats_outstanding();
         return awaited_beats.size();
      endfunction

      // One line per mismatch, and the count goes up.
      task report_mismatch(string what);
         $display("MISMATCH %s", what);
         errors++;
      endtask

      task check_beat(walk_beat_type got);
         walk_beat_type want;
         beat_count++;
         if (awaited_beats.size() == 0) begin
            report_mismatch($sformatf("beat %0d: edge %0d arrived with nothing expected",
                                      beat_count, got.edge_id));
            return;
         end
         want = awaited_beats.pop_front();
         if (got.edge_id !== want.edge_id)
            report_mismatch($sformatf("beat %0d: edge_id %0d, expected %0d",
                                      beat_count, got.edge_id, want.edge_id));
         if (got.last !== want.last)
            report_mismatch($sformatf("beat %0d (edge %0d): last %0d, expected %0d",
                                      beat_count, want.edge_id, got.last, want.last));
         if (got.status !== want.status)
            report_mismatch($sformatf("beat %0d (edge %0d): status %0d, expected %0d",
                                      beat_count, want.edge_id, got.status, want.status));
      endtask
   endclass

endpackage

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - regression bench for winged_edge_ring_walker_core
// Loads winged-edge records, walks face rings and checks every result beat
// against a predictor that mirrors the edge table, under random flow control.
// ----------------------------------------------------------------------------
module tb_top;
   import werw_pkg::*;
   import ring_walk_scoreboard_pkg::*;

   localparam int IdMax       = (1 << EdgeIdWidth) - 1;
   localparam int FaceMax     = (1 << FaceWidth) - 1;
   localparam int HoldCycles  = 200;
   localparam int StallLimit  = 2000;
   localparam int DrainCycles = 16;
   localparam int RandomItems = 230;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_type;
   logic [EdgeIdWidth-1:0] req_edge_addr;
   logic [FaceWidth-1:0]   req_left_face;
   logic [FaceWidth-1:0]   req_right_face;
   logic [EdgeIdWidth-1:0] req_left_next;
   logic [EdgeIdWidth-1:0] req_right_next;
   logic [EdgeIdWidth-1:0] req_start_edge;
   logic [FaceWidth-1:0]   req_walk_face;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [EdgeIdWidth-1:0] rsp_edge_id;
   logic                   rsp_last;
   logic [StatusWidth-1:0] rsp_status;

   // The checker follows what the block actually accepts. The planner is a
   // second copy of the table, updated as requests are generated; since
   // requests go out strictly in order, it tells the generator ahead of time
   // whether a walk would ever step onto a record that was never loaded.
   ring_walk_scoreboard sb      = new();
   ring_walk_scoreboard planned = new();

   bit no_gaps;          // both sides run without idle cycles
   bit hold_request;     // asks the receiver for one long hold-off
   int counted_items;    // accepted requests that the block acts on

   winged_edge_ring_walker_core #(
      .NUM_EDGES      (TableDepth),
      .MAX_RING_EDGES (RingLimit)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_edge_addr  (req_edge_addr),
      .req_left_face  (req_left_face),
      .req_right_face (req_right_face),
      .req_left_next  (req_left_next),
      .req_right_next (req_right_next),
      .req_start_edge (req_start_edge),
      .req_walk_face  (req_walk_face),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_edge_id    (rsp_edge_id),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Request side. Payloads change on the falling edge only; a beat counts
   // once valid and ready are both seen high at a rising edge.
   // ------------------------------------------------------------------------

   // Presents one beat and returns right after the edge that takes it. The
   // valid stays high on return, so a following beat can go out back to back.
   task automatic send_request(input ring_request_type rq);
      @(negedge clock);
      while (!no_gaps && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_type       <= rq.kind;
      req_edge_addr  <= rq.edge_addr;
      req_left_face  <= rq.left_face;
      req_right_face <= rq.right_face;
      req_left_next  <= rq.left_next;
      req_right_next <= rq.right_next;
      req_start_edge <= rq.start_edge;
      req_walk_face  <= rq.walk_face;
      req_valid      <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Fields that a request does not use still carry random values, so the
   // block is seen to ignore them.
   function automatic ring_request_type random_request();
      ring_request_type rq;
      rq.kind       = $urandom_range(0, 1);
      rq.edge_addr  = $urandom_range(0, IdMax);
      rq.left_face  = $urandom_range(0, FaceMax);
      rq.right_face = $urandom_range(0, FaceMax);
      rq.left_next  = $urandom_range(0, IdMax);
      rq.right_next = $urandom_range(0, IdMax);
      rq.start_edge = $urandom_range(0, IdMax);
      rq.walk_face  = $urandom_range(0, FaceMax);
      return rq;
   endfunction

   function automatic edge_rec_type make_rec(input int lf, input int rf,
                                             input int ln, input int rn);
      edge_rec_type rec;
      rec.left_face  = lf;
      rec.right_face = rf;
      rec.left_next  = ln;
      rec.right_next = rn;
      return rec;
   endfunction

   task automatic send_write(input logic [EdgeIdWidth-1:0] addr, input edge_rec_type rec);
      ring_request_type rq;
      rq            = random_request();
      rq.kind       = ReqWrite;
      rq.edge_addr  = addr;
      rq.left_face  = rec.left_face;
      rq.right_face = rec.right_face;
      rq.left_next  = rec.left_next;
      rq.right_next = rec.right_next;
      planned.store_record(addr, rec);
      // A write outside the table is dropped by the block and does not count.
      if (addr != 0 && addr <= TableDepth) counted_items++;
      send_request(rq);
   endtask

   // Walks that would step onto a never-loaded record are simply not issued.
   task automatic send_walk(input logic [EdgeIdWidth-1:0] start,
                            input logic [FaceWidth-1:0] face);
      ring_request_type rq;
      if (planned.trace_walk(start, face)) return;
      rq            = random_request();
      rq.kind       = ReqWalk;
      rq.start_edge = start;
      rq.walk_face  = face;
      counted_items++;
      send_request(rq);
   endtask

   // Loads a closed ring of distinct edges around one face, with the face on
   // a random side of each edge, then walks it from random members. Now and
   // then a link is broken or an edge gets the same face on both sides, so
   // the error endings turn up inside otherwise sound rings.
   task automatic build_ring(input int ring_len);
      logic [EdgeIdWidth-1:0] members [$];
      bit                     taken [0:TableDepth];
      logic [FaceWidth-1:0]   face;
      logic [FaceWidth-1:0]   other;
      logic [FaceWidth-1:0]   walk_face;
      logic [EdgeIdWidth-1:0] id;
      logic [EdgeIdWidth-1:0] onward;
      logic [EdgeIdWidth-1:0] spare;
      int                     walks;
      face = $urandom_range(0, FaceMax);
      while (members.size() < ring_len) begin
         id = $urandom_range(1, TableDepth);
         if (!taken[id]) begin
            taken[id] = 1'b1;
            members.push_back(id);
         end
      end
      foreach (members[i]) begin
         onward = members[(i + 1) % ring_len];
         if ($urandom_range(0, 14) == 0) onward = $urandom_range(0, IdMax);
         if ($urandom_range(0, 19) == 0) other = face;
         else other = face + $urandom_range(1, FaceMax);
         spare = $urandom_range(0, IdMax);
         if ($urandom_range(0, 1) == 1) begin
            send_write(members[i], make_rec(other, face, spare, onward));
         end else begin
            send_write(members[i], make_rec(face, other, onward, spare));
         end
      end
      walks = $urandom_range(1, 3);
      repeat (walks) begin
         id = members[$urandom_range(0, ring_len - 1)];
         case ($urandom_range(0, 7))
            0: begin
               walk_face = $urandom_range(0, FaceMax);
            end
            1: begin
               // Walk the neighboring face instead; it usually runs off the
               // ring and is dropped by the planner unless it stays inside.
               walk_face = planned.edge_recs[id].left_face;
               if (walk_face == face) walk_face = planned.edge_recs[id].right_face;
            end
            default: begin
               walk_face = face;
            end
         endcase
         send_walk(id, walk_face);
      end
   endtask

   // Walks from a loaded edge along one of its faces, or from any id at all.
   task automatic random_walk();
      logic [EdgeIdWidth-1:0] start;
      logic [FaceWidth-1:0]   face;
      start = $urandom_range(0, IdMax);
      face  = $urandom_range(0, FaceMax);
      if (planned.written_ids.size() != 0 && $urandom_range(0, 3) != 0) begin
         start = planned.written_ids[$urandom_range(0, planned.written_ids.size() - 1)];
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 1) == 1) face = planned.edge_recs[start].left_face;
            else face = planned.edge_recs[start].right_face;
         end
      end
      send_walk(start, face);
   endtask

   // Fully random record, to a random address or over a loaded edge.
   task automatic noise_write();
      logic [EdgeIdWidth-1:0] addr;
      addr = $urandom_range(0, IdMax);
      if (planned.written_ids.size() != 0 && $urandom_range(0, 1) == 1)
         addr = planned.written_ids[$urandom_range(0, planned.written_ids.size() - 1)];
      send_write(addr, make_rec($urandom_range(0, FaceMax), $urandom_range(0, FaceMax),
                                $urandom_range(0, IdMax), $urandom_range(0, IdMax)));
   endtask

   // ------------------------------------------------------------------------
   // Stimulus: reset, a directed opening, then mostly ring sequences.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int seq;
      int random_base;
      int choice;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = ReqWrite;
      req_edge_addr  = '0;
      req_left_face  = '0;
      req_right_face = '0;
      req_left_next  = '0;
      req_right_next = '0;
      req_start_edge = '0;
      req_walk_face  = '0;
      no_gaps        = 1'b0;
      hold_request   = 1'b0;
      counted_items  = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Writes to id zero and past the end of the table must vanish.
      send_write(0, make_rec(FaceMax, 0, IdMax, IdMax));
      send_write(TableDepth + 1, make_rec(0, FaceMax, 0, 0));
      send_write(IdMax, make_rec(FaceMax, FaceMax, TableDepth, TableDepth));

      // Top and bottom of the table, extreme face ids, and several ways a walk
      // can stop: closing on itself, a face that is not on the edge, a link
      // past the table and a link of zero.
      send_write(TableDepth, make_rec(5, FaceMax, 0, IdMax));
      send_write(1, make_rec(0, FaceMax, TableDepth, 1));
      send_walk(1, FaceMax);
      send_walk(1, 0);
      send_walk(TableDepth, FaceMax);
      send_walk(TableDepth, 5);

      // Start ids outside the table give a single bad-id beat.
      send_walk(0, 0);
      send_walk(TableDepth + 1, FaceMax);
      send_walk(IdMax, 512);

      // Same face on both sides of the start edge.
      send_write(2, make_rec(7, 7, 3, 3));
      send_walk(2, 7);

      // Edge 4 leads into edge 3, which loops onto itself on the left and so
      // never returns to the start: the ring-too-long ending. The receiver
      // holds off meanwhile, so the block backs up and stalls its input
      // while the sender keeps offering beats.
      send_write(4, make_rec(300, 100, 0, 3));
      send_write(3, make_rec(100, 200, 3, 4));
      hold_request = 1'b1;
      send_walk(4, 100);
      send_walk(3, 200);

      // A short sound ring with the face on alternating sides.
      send_write(10, make_rec(1, 50, 0, 11));
      send_write(11, make_rec(50, 2, 12, 0));
      send_write(12, make_rec(3, 50, 0, 10));
      send_walk(11, 50);

      // Random part. Two early sequences close rings of exactly the length
      // limit and one edge over it; a stretch in the middle runs with no
      // idle cycles on either side.
      seq = 0;
      random_base = counted_items;
      while (counted_items - random_base < RandomItems) begin
         no_gaps = (counted_items - random_base >= 100) &&
                   (counted_items - random_base < 150);
         choice = $urandom_range(0, 99);
         if (choice < 65) begin
            if (seq == 1) build_ring(RingLimit);
            else if (seq == 4) build_ring(RingLimit + 1);
            else if ($urandom_range(0, 11) == 0) build_ring($urandom_range(40, 70));
            else build_ring($urandom_range(1, 12));
            seq++;
         end else if (choice < 85) begin
            random_walk();
         end else begin
            noise_write();
         end
      end
      no_gaps = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.beats_outstanding() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (sb.errors == 0 && sb.beats_outstanding() == 0) begin
         $display("winged_edge_ring_walker_core regression: pass");
      end else begin
         $display("winged_edge_ring_walker_core regression: fail");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Result side. Ready idles at random, stays high throughout the stretch
   // without gaps, and once goes low for a long hold-off counted here.
   // ------------------------------------------------------------------------
   initial begin : receiver
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= no_gaps || ($urandom_range(0, 99) >= 28);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: every accepted request is handed to the predictor, every
   // accepted result beat is checked against the oldest expectation.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      ring_request_type seen_req;
      walk_beat_type    seen_beat;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen_req.kind       = req_type;
            seen_req.edge_addr  = req_edge_addr;
            seen_req.left_face  = req_left_face;
            seen_req.right_face = req_right_face;
            seen_req.left_next  = req_left_next;
            seen_req.right_next = req_right_next;
            seen_req.start_edge = req_start_edge;
            seen_req.walk_face  = req_walk_face;
            sb.note_request(seen_req);
         end
         if (rsp_valid && rsp_ready) begin
            seen_beat.edge_id = rsp_edge_id;
            seen_beat.last    = rsp_last;
            seen_beat.status  = rsp_status;
            sb.check_beat(seen_beat);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: no legal silence lasts much past the receiver's hold-off, so a
   // long run with no beat on either channel means a hang.
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int silent_cycles;
      silent_cycles = 0;
      while (silent_cycles < StallLimit) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            silent_cycles = 0;
         else
            silent_cycles++;
      end
      $display("winged_edge_ring_walker_core regression: fail");
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/werw_pkg.sv
src/werw_ram.sv
src/werw_ctrl.sv
src/werw_dp.sv
src/winged_edge_ring_walker_core.sv
src/werw_checker.sv
test/ring_walk_scoreboard_pkg.sv
test/tb_top.sv
